// ----- design/lvbm_pkg.sv -----
// Shared constants and types for the Laplacian-variance blur metric.
package lvbm_pkg;

    localparam int MAX_WIDTH_DEF  = 640;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int LUMA_W    = 8;
    localparam int VAR_W     = 28;
    localparam int MEAN_W    = 19;
    localparam int FRAC_W    = 8;
    localparam int LAP_W     = 11;
    localparam int SQ_W      = 20;
    localparam int MIN_DIM   = 3;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [VAR_W-1:0]         VAR_SAT      = {VAR_W{1'b1}};
    localparam logic signed [MEAN_W-1:0] MEAN_POS_SAT = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic signed [MEAN_W-1:0] MEAN_NEG_SAT = {1'b1, {(MEAN_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

endpackage

// ----- design/lvbm_front.sv -----
// Front end: geometry registers, raster counters, line memory, 3x3 window and sums.
module lvbm_front #(
    parameter int MAX_WIDTH  = lvbm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lvbm_pkg::MAX_HEIGHT_DEF
) (
    i_clk,
    i_rst_n,
    i_cfg_wr_en,
    i_cfg_index,
    i_cfg_data,
    i_valid,
    i_luma,
    o_stall,
    i_q_count,
    o_push,
    o_push_data
);
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int GW      = CW + 1;
    localparam int HW      = RW + 1;
    localparam int NW      = CW + RW;
    localparam int SW      = NW + lvbm_pkg::LAP_W;
    localparam int QW      = NW + lvbm_pkg::SQ_W;
    localparam int ENTRY_W = NW + SW + QW;
    localparam int DEPTH   = lvbm_pkg::QUEUE_DEPTH;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LW      = lvbm_pkg::LUMA_W;
    localparam int W_RST   = (lvbm_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                 : lvbm_pkg::WIDTH_RESET;
    localparam int H_RST   = (lvbm_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                   : lvbm_pkg::HEIGHT_RESET;

    input  logic                           i_clk;
    input  logic                           i_rst_n;
    input  logic                           i_cfg_wr_en;
    input  logic [lvbm_pkg::CFG_IDX_W-1:0] i_cfg_index;
    input  logic [lvbm_pkg::CFG_W-1:0]     i_cfg_data;
    input  logic                           i_valid;
    input  logic [LW-1:0]                  i_luma;
    output logic                           o_stall;
    input  logic [CNT_W-1:0]               i_q_count;
    output logic                           o_push;
    output logic [ENTRY_W-1:0]             o_push_data;

    // Geometry, already clamped to the legal range.
    logic [GW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [GW-1:0] clamp_w;
    logic [HW-1:0] clamp_h;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic [2*LW-1:0] r_line_mem [MAX_WIDTH];
    logic [2*LW-1:0] r_rd;

    // Stage A: line memory data is available.
    logic          r_a_valid;
    logic [LW-1:0] r_a_pix;
    logic [CW-1:0] r_a_idx;
    logic          r_a_int;
    logic          r_a_last;
    logic [NW-1:0] r_a_n;

    // Window: left neighbour (middle row of column c-2) and column c-1.
    logic [LW-1:0] r_w_left;
    logic [LW-1:0] r_w_top;
    logic [LW-1:0] r_w_mid;
    logic [LW-1:0] r_w_bot;

    // Stage B: accumulate.
    logic                                r_b_valid;
    logic signed [lvbm_pkg::LAP_W-1:0]   r_b_lap;
    logic                                r_b_int;
    logic                                r_b_last;
    logic [NW-1:0]                       r_b_n;

    logic signed [SW-1:0] r_sum;
    logic [QW-1:0]        r_sq;

    logic                 accept;
    logic [GW-1:0]        col_inc;
    logic [HW-1:0]        row_inc;
    logic                 col_end;
    logic                 row_end;
    logic                 interior;
    logic [RW-1:0]        h_m2;
    logic [CW-1:0]        w_m2;
    logic [NW-1:0]        frame_n;
    logic [LW-1:0]        top;
    logic [LW-1:0]        mid;
    logic [lvbm_pkg::LAP_W-1:0] lap_pos;
    logic [lvbm_pkg::LAP_W-1:0] lap;
    logic signed [2*lvbm_pkg::LAP_W-1:0] lap_sq;
    logic signed [SW-1:0] lap_ext;
    logic [QW-1:0]        sq_ext;
    logic signed [SW-1:0] sum_next;
    logic [QW-1:0]        sq_next;
    logic [CNT_W:0]       committed;

    always_comb begin
        if (i_cfg_data < lvbm_pkg::CFG_W'(lvbm_pkg::MIN_DIM)) begin
            clamp_w = GW'(lvbm_pkg::MIN_DIM);
        end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
            clamp_w = GW'(MAX_WIDTH);
        end else begin
            clamp_w = GW'(i_cfg_data);
        end
        if (i_cfg_data < lvbm_pkg::CFG_W'(lvbm_pkg::MIN_DIM)) begin
            clamp_h = HW'(lvbm_pkg::MIN_DIM);
        end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
            clamp_h = HW'(MAX_HEIGHT);
        end else begin
            clamp_h = HW'(i_cfg_data);
        end
    end

    // Credit check: every frame end already in flight must find room in the queue.
    assign committed = {1'b0, i_q_count}
                     + (CNT_W + 1)'(r_a_valid & r_a_last)
                     + (CNT_W + 1)'(r_b_valid & r_b_last);
    assign o_stall   = committed >= (CNT_W + 1)'(DEPTH);
    assign accept    = i_valid && !o_stall;

    assign col_inc  = {1'b0, r_col} + GW'(1);
    assign row_inc  = {1'b0, r_row} + HW'(1);
    assign col_end  = col_inc >= r_width;
    assign row_end  = row_inc >= r_height;
    assign interior = (r_row >= RW'(2)) && (r_col >= CW'(2));
    assign h_m2     = RW'(r_height - HW'(2));
    assign w_m2     = CW'(r_width - GW'(2));
    assign frame_n  = NW'(h_m2) * NW'(w_m2);

    assign top     = r_rd[2*LW-1:LW];
    assign mid     = r_rd[LW-1:0];
    // up + left + right + down - 4*centre, modulo 2^11; the true value fits.
    assign lap_pos = lvbm_pkg::LAP_W'(r_w_top) + lvbm_pkg::LAP_W'(r_w_left)
                   + lvbm_pkg::LAP_W'(mid) + lvbm_pkg::LAP_W'(r_w_bot);
    assign lap     = lap_pos - lvbm_pkg::LAP_W'({r_w_mid, 2'b00});

    assign lap_sq   = r_b_lap * r_b_lap;
    assign lap_ext  = r_b_int ? SW'(r_b_lap) : '0;
    assign sq_ext   = r_b_int ? QW'(lap_sq[lvbm_pkg::SQ_W-1:0]) : '0;
    assign sum_next = r_sum + lap_ext;
    assign sq_next  = r_sq + sq_ext;

    assign o_push      = r_b_valid && r_b_last;
    assign o_push_data = {r_b_n, sum_next, sq_next};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_line_mem[r_col];
        end
        if (r_a_valid) begin
            r_line_mem[r_a_idx] <= {mid, r_a_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= GW'(W_RST);
            r_height  <= HW'(H_RST);
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_w_left  <= '0;
            r_w_top   <= '0;
            r_w_mid   <= '0;
            r_w_bot   <= '0;
            r_sum     <= '0;
            r_sq      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (lvbm_pkg::t_cfg_index'(i_cfg_index))
                    lvbm_pkg::CFG_FRAME_WIDTH:  r_width  <= clamp_w;
                    lvbm_pkg::CFG_FRAME_HEIGHT: r_height <= clamp_h;
                endcase
            end

            r_a_valid <= accept;
            if (accept) begin
                r_a_pix  <= i_luma;
                r_a_idx  <= r_col;
                r_a_int  <= interior;
                r_a_last <= col_end && row_end;
                r_a_n    <= frame_n;
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : RW'(row_inc);
                end else begin
                    r_col <= CW'(col_inc);
                end
            end

            r_b_valid <= r_a_valid;
            if (r_a_valid) begin
                r_b_lap  <= lap;
                r_b_int  <= r_a_int;
                r_b_last <= r_a_last;
                r_b_n    <= r_a_n;
                r_w_left <= r_w_mid;
                r_w_top  <= top;
                r_w_mid  <= mid;
                r_w_bot  <= r_a_pix;
            end

            if (r_b_valid) begin
                if (r_b_last) begin
                    r_sum <= '0;
                    r_sq  <= '0;
                end else begin
                    r_sum <= sum_next;
                    r_sq  <= sq_next;
                end
            end
        end
    end

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_q_count < CNT_W'(DEPTH)))
        else $error("frame result pushed into a full queue");

    a_counters_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_last) |-> (r_col == '0 && r_row == '0))
        else $error("raster counters did not wrap at frame end");

endmodule

// ----- design/lvbm_queue.sv -----
// Short result queue between the pixel front end and the statistics back end.
module lvbm_queue #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = lvbm_pkg::QUEUE_DEPTH
) (
    i_clk,
    i_rst_n,
    i_push,
    i_push_data,
    i_pop,
    o_valid,
    o_data,
    o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    input  logic              i_clk;
    input  logic              i_rst_n;
    input  logic              i_push;
    input  logic [DATA_W-1:0] i_push_data;
    input  logic              i_pop;
    output logic              o_valid;
    output logic [DATA_W-1:0] o_data;
    output logic [CNT_W-1:0]  o_count;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- design/lvbm_back.sv -----
// Back end: sequential multiplier and divider that turn the sums into mean and variance.
module lvbm_back #(
    parameter int MAX_WIDTH  = lvbm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lvbm_pkg::MAX_HEIGHT_DEF
) (
    i_clk,
    i_rst_n,
    i_q_valid,
    i_q_data,
    o_pop,
    o_valid,
    i_stall,
    o_blur_variance_q8,
    o_laplacian_mean_q8
);
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int NW      = CW + RW;
    localparam int SW      = NW + lvbm_pkg::LAP_W;
    localparam int QW      = NW + lvbm_pkg::SQ_W;
    localparam int ENTRY_W = NW + SW + QW;
    localparam int PW      = 2 * SW;
    localparam int DVW     = 2 * NW;
    localparam int NUMW    = PW + lvbm_pkg::FRAC_W;
    localparam int VW      = lvbm_pkg::VAR_W;
    localparam int MW      = lvbm_pkg::MEAN_W;
    localparam int CNT_MAX = (SW > VW) ? SW : VW;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    input  logic               i_clk;
    input  logic               i_rst_n;
    input  logic               i_q_valid;
    input  logic [ENTRY_W-1:0] i_q_data;
    output logic               o_pop;
    output logic               o_valid;
    input  logic               i_stall;
    output logic [VW-1:0]      o_blur_variance_q8;
    output logic signed [MW-1:0] o_laplacian_mean_q8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DEN,
        S_MUL_NSS,
        S_MUL_SS,
        S_DIFF,
        S_VDIV,
        S_MCHK,
        S_MDIV,
        S_DONE
    } t_state;

    t_state r_state;

    logic [NW-1:0]    r_n;
    logic             r_neg;
    logic [SW-1:0]    r_mag;
    logic [QW-1:0]    r_ss;
    logic [PW-1:0]    r_prod;
    logic [PW-1:0]    r_mc;
    logic [SW-1:0]    r_mp;
    logic [CNT_W-1:0] r_cnt;
    logic [DVW-1:0]   r_den;
    logic [PW-1:0]    r_p;
    logic [DVW-1:0]   r_rem;
    logic [VW-1:0]    r_low;
    logic [VW-1:0]    r_quo;
    logic [VW-1:0]    r_var;
    logic [MW-1:0]    r_mean;
    logic             r_out_valid;
    logic [VW-1:0]    r_out_var;
    logic [MW-1:0]    r_out_mean;

    logic [NW-1:0]    q_n;
    logic [SW-1:0]    q_sum;
    logic [QW-1:0]    q_ss;
    logic [PW-1:0]    prod_next;
    logic             last_step;
    logic [DVW:0]     div_shift;
    logic             div_ge;
    logic [DVW:0]     div_diff;
    logic [DVW-1:0]   rem_next;
    logic [VW-1:0]    quo_next;
    logic [PW-1:0]    var_diff;
    logic [NUMW-1:0]  var_num;
    logic [NUMW-1:0]  var_hi;
    logic             var_sat;
    logic [NUMW-1:0]  mean_num;
    logic [NUMW-1:0]  mean_hi;
    logic             mean_sat;
    logic [MW-1:0]    mean_mag;
    logic [MW-1:0]    mean_val;
    logic             out_free;

    assign q_n   = i_q_data[ENTRY_W-1 -: NW];
    assign q_sum = i_q_data[SW+QW-1 -: SW];
    assign q_ss  = i_q_data[QW-1:0];

    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign out_free = !r_out_valid || !i_stall;

    // One bit of the multiplier per cycle.
    assign prod_next = r_prod + (r_mp[0] ? r_mc : '0);
    assign last_step = r_cnt == CNT_W'(1);

    // One restoring-division step per cycle.
    assign div_shift = {r_rem, r_low[VW-1]};
    assign div_ge    = div_shift >= {1'b0, r_den};
    assign div_diff  = div_shift - {1'b0, r_den};
    assign rem_next  = div_ge ? div_diff[DVW-1:0] : div_shift[DVW-1:0];
    assign quo_next  = {r_quo[VW-2:0], div_ge};

    assign var_diff = r_p - r_prod;
    assign var_num  = {var_diff, {lvbm_pkg::FRAC_W{1'b0}}};
    assign var_hi   = var_num >> VW;
    assign var_sat  = var_hi >= NUMW'(r_den);

    assign mean_num = NUMW'(r_mag) << lvbm_pkg::FRAC_W;
    assign mean_hi  = mean_num >> (MW - 1);
    assign mean_sat = mean_hi >= NUMW'(r_n);
    assign mean_mag = {1'b0, quo_next[MW-2:0]};
    assign mean_val = r_neg ? (MW'(0) - mean_mag) : mean_mag;

    assign o_valid             = r_out_valid;
    assign o_blur_variance_q8  = r_out_var;
    assign o_laplacian_mean_q8 = r_out_mean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills in S_DONE and empties when the receiver takes it.
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_n    <= q_n;
                        r_neg  <= q_sum[SW-1];
                        r_mag  <= q_sum[SW-1] ? (SW'(0) - q_sum) : q_sum;
                        r_ss   <= q_ss;
                        r_mc   <= PW'(q_n);
                        r_mp   <= SW'(q_n - NW'(1));
                        r_prod <= '0;
                        r_cnt  <= CNT_W'(SW);
                        r_state <= S_MUL_DEN;
                    end
                end

                S_MUL_DEN, S_MUL_NSS, S_MUL_SS: begin
                    if (!last_step) begin
                        r_prod <= prod_next;
                        r_mc   <= r_mc << 1;
                        r_mp   <= r_mp >> 1;
                        r_cnt  <= r_cnt - CNT_W'(1);
                    end else begin
                        unique case (r_state)
                            S_MUL_DEN: begin
                                r_den   <= prod_next[DVW-1:0];
                                r_mc    <= PW'(r_ss);
                                r_mp    <= SW'(r_n);
                                r_prod  <= '0;
                                r_cnt   <= CNT_W'(SW);
                                r_state <= S_MUL_NSS;
                            end
                            S_MUL_NSS: begin
                                r_p     <= prod_next;
                                r_mc    <= PW'(r_mag);
                                r_mp    <= r_mag;
                                r_prod  <= '0;
                                r_cnt   <= CNT_W'(SW);
                                r_state <= S_MUL_SS;
                            end
                            default: begin
                                r_prod  <= prod_next;
                                r_state <= S_DIFF;
                            end
                        endcase
                    end
                end

                S_DIFF: begin
                    // No variance for a single sample or a negative numerator.
                    if (r_n < NW'(2) || r_p < r_prod) begin
                        r_var   <= '0;
                        r_state <= S_MCHK;
                    end else if (var_sat) begin
                        r_var   <= lvbm_pkg::VAR_SAT;
                        r_state <= S_MCHK;
                    end else begin
                        r_rem   <= var_hi[DVW-1:0];
                        r_low   <= var_num[VW-1:0];
                        r_quo   <= '0;
                        r_cnt   <= CNT_W'(VW);
                        r_state <= S_VDIV;
                    end
                end

                S_VDIV, S_MDIV: begin
                    r_rem <= rem_next;
                    r_low <= r_low << 1;
                    r_quo <= quo_next;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (last_step) begin
                        if (r_state == S_VDIV) begin
                            r_var   <= quo_next;
                            r_state <= S_MCHK;
                        end else begin
                            r_mean  <= mean_val;
                            r_state <= S_DONE;
                        end
                    end
                end

                S_MCHK: begin
                    if (mean_sat) begin
                        r_mean  <= r_neg ? lvbm_pkg::MEAN_NEG_SAT : lvbm_pkg::MEAN_POS_SAT;
                        r_state <= S_DONE;
                    end else begin
                        r_rem   <= mean_hi[DVW-1:0];
                        r_den   <= DVW'(r_n);
                        r_low   <= {mean_num[MW-2:0], {(VW - MW + 1){1'b0}}};
                        r_quo   <= '0;
                        r_cnt   <= CNT_W'(MW - 1);
                        r_state <= S_MDIV;
                    end
                end

                S_DONE: begin
                    if (out_free) begin
                        r_out_var   <= r_var;
                        r_out_mean  <= r_mean;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_div_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VDIV || r_state == S_MDIV) |-> (r_rem < r_den))
        else $error("division remainder not below divisor");

    a_step_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_DEN || r_state == S_MUL_NSS || r_state == S_MUL_SS
         || r_state == S_VDIV || r_state == S_MDIV) |-> (r_cnt != '0))
        else $error("step counter ran out inside a multi-cycle operation");

endmodule

// ----- design/laplacian_variance_blur_metric.sv -----
// Top level of the variance-of-Laplacian focus measure.
//
//  Channel   Direction  Handshake            Beat contents
//  -------   ---------  -------------------  --------------------------------------------
//  config    in         i_cfg_wr_en          i_cfg_index (0 width, 1 height), i_cfg_data
//  pixel     in         i_valid / o_stall    i_luma, raster order
//  result    out        o_valid / i_stall    o_blur_variance_q8, o_laplacian_mean_q8
//
// A pixel beat is taken every clock while o_stall is low; the front end reads the line
// memory at accept, forms the Laplacian in stage A and adds it to the running sums in stage B.
// One result beat follows the last pixel of each frame. The back end computes it with
// the bit-serial multiplier (three products) and the one-bit-per-cycle divider.
// Frame results wait in a four-entry queue; o_stall rises only while four frame ends
// are queued or in flight, so a stalled result port stalls pixels only after that.
// Reset is synchronous and active low; the line memory needs no clearing pass.
module laplacian_variance_blur_metric #(
    parameter int MAX_WIDTH  = lvbm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lvbm_pkg::MAX_HEIGHT_DEF
) (
    i_clk,
    i_rst_n,
    i_cfg_wr_en,
    i_cfg_index,
    i_cfg_data,
    i_valid,
    o_stall,
    i_luma,
    o_valid,
    i_stall,
    o_blur_variance_q8,
    o_laplacian_mean_q8
);
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int NW      = CW + RW;
    localparam int SW      = NW + lvbm_pkg::LAP_W;
    localparam int QW      = NW + lvbm_pkg::SQ_W;
    localparam int ENTRY_W = NW + SW + QW;
    localparam int CNT_W   = $clog2(lvbm_pkg::QUEUE_DEPTH + 1);

    input  logic                               i_clk;
    input  logic                               i_rst_n;
    input  logic                               i_cfg_wr_en;
    input  logic [lvbm_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    input  logic [lvbm_pkg::CFG_W-1:0]         i_cfg_data;
    input  logic                               i_valid;
    output logic                               o_stall;
    input  logic [lvbm_pkg::LUMA_W-1:0]        i_luma;
    output logic                               o_valid;
    input  logic                               i_stall;
    output logic [lvbm_pkg::VAR_W-1:0]         o_blur_variance_q8;
    output logic signed [lvbm_pkg::MEAN_W-1:0] o_laplacian_mean_q8;

    // Front end to queue: one entry per finished frame (interior pixel count, sum, square sum).
    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic [CNT_W-1:0]   q_count;

    // Queue to back end.
    logic               q_valid;
    logic [ENTRY_W-1:0] q_data;
    logic               pop;

    lvbm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_luma      (i_luma),
        .o_stall     (o_stall),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_push_data (push_data)
    );

    lvbm_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (lvbm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .o_count     (q_count)
    );

    lvbm_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_data            (q_data),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_blur_variance_q8  (o_blur_variance_q8),
        .o_laplacian_mean_q8 (o_laplacian_mean_q8)
    );

endmodule

// ----- test/laplacian_variance_blur_metric_checker.sv -----
`timescale 1ns / 1ps
// Predicts the per-frame focus statistics from the pixel beats and compares every result beat.
module laplacian_variance_blur_metric_checker
    import lvbm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  t_cfg_index               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    input  logic                     o_stall,
    input  logic [LUMA_W-1:0]        i_luma,
    input  logic                     o_valid,
    input  logic                     i_stall,
    input  logic [VAR_W-1:0]         o_blur_variance_q8,
    input  logic signed [MEAN_W-1:0] o_laplacian_mean_q8,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int LINE_LEN = MAX_WIDTH_DEF;

    typedef struct {
        logic [VAR_W-1:0]         variance;
        logic signed [MEAN_W-1:0] mean;
    } focus_stats_t;

    focus_stats_t stats_due[$];
    focus_stats_t oldest_due;
    int mismatches = 0;

    // Mirror of the block: two previous rows, a two-column window and the running sums.
    logic [LUMA_W-1:0] row_up1 [LINE_LEN];
    logic [LUMA_W-1:0] row_up2 [LINE_LEN];
    logic [LUMA_W-1:0] win [6];
    int unsigned       col_pos;
    int unsigned       row_pos;
    longint            lap_sum;
    longint unsigned   lap_sq_sum;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;

    assign o_fail_count = mismatches;

    function automatic int unsigned fit_dim(input logic [CFG_W-1:0] raw, input int unsigned hi);
        if (raw < MIN_DIM) return MIN_DIM;
        if (raw > hi) return hi;
        return raw;
    endfunction

    // Mean and unbiased variance of the interior Laplacian values, both Q8 and truncated.
    function automatic focus_stats_t frame_stats(input int unsigned w, input int unsigned h);
        logic [63:0]         n;
        logic [63:0]         mag;
        logic [63:0]         qm;
        logic signed [63:0]  m;
        logic [127:0]        prod_a;
        logic [127:0]        prod_b;
        logic [127:0]        quo;
        focus_stats_t        fs;
        n   = 64'(h - 2) * 64'(w - 2);
        mag = (lap_sum < 0) ? 64'(-lap_sum) : 64'(lap_sum);
        qm  = (mag << FRAC_W) / n;
        m   = qm;
        if (lap_sum < 0) m = -m;
        if (m > 64'sd262143) fs.mean = MEAN_POS_SAT;
        else if (m < -64'sd262144) fs.mean = MEAN_NEG_SAT;
        else fs.mean = m[MEAN_W-1:0];
        fs.variance = '0;
        if (n >= 2) begin
            prod_a = 128'(n) * 128'(lap_sq_sum);
            prod_b = 128'(mag) * 128'(mag);
            if (prod_a >= prod_b) begin
                quo = ((prod_a - prod_b) << FRAC_W) / (128'(n) * 128'(n - 1));
                fs.variance = (quo > 128'(VAR_SAT)) ? VAR_SAT : quo[VAR_W-1:0];
            end
        end
        return fs;
    endfunction

    task automatic absorb_pixel(input logic [LUMA_W-1:0] pix);
        int unsigned       w;
        int unsigned       h;
        int unsigned       c;
        int unsigned       idx;
        logic [LUMA_W-1:0] top;
        logic [LUMA_W-1:0] mid;
        longint            lap;
        w   = fit_dim(width_reg, MAX_WIDTH_DEF);
        h   = fit_dim(height_reg, MAX_HEIGHT_DEF);
        c   = col_pos;
        idx = (c < LINE_LEN) ? c : LINE_LEN - 1;
        top = row_up2[idx];
        mid = row_up1[idx];
        if (row_pos >= 2 && c >= 2) begin
            lap = longint'(win[3]) + longint'(win[1]) + longint'(mid) + longint'(win[5])
                - 4 * longint'(win[4]);
            lap_sum    += lap;
            lap_sq_sum += longint'(lap * lap);
        end
        row_up2[idx] = mid;
        row_up1[idx] = pix;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = pix;
        if (c + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                stats_due.push_back(frame_stats(w, h));
                row_pos    = 0;
                lap_sum    = 0;
                lap_sq_sum = 0;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LINE_LEN; i++) begin
                row_up1[i] = '0;
                row_up2[i] = '0;
            end
            for (int i = 0; i < 6; i++) win[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            lap_sum    = 0;
            lap_sq_sum = 0;
            width_reg  = CFG_W'(WIDTH_RESET);
            height_reg = CFG_W'(HEIGHT_RESET);
            stats_due.delete();
        end else begin
            // A result beat never belongs to a pixel taken at the same edge.
            if (o_valid && !i_stall) begin
                if (stats_due.size() == 0) begin
                    $error("result beat with no frame pending: variance %0d, mean %0d",
                           o_blur_variance_q8, o_laplacian_mean_q8);
                    mismatches++;
                end else begin
                    oldest_due = stats_due.pop_front();
                    if (o_blur_variance_q8 !== oldest_due.variance) begin
                        $error("blur_variance_q8: expected %0d, actual %0d",
                               oldest_due.variance, o_blur_variance_q8);
                        mismatches++;
                    end
                    if (o_laplacian_mean_q8 !== oldest_due.mean) begin
                        $error("laplacian_mean_q8: expected %0d, actual %0d",
                               oldest_due.mean, o_laplacian_mean_q8);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  width_reg = i_cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) absorb_pixel(i_luma);
        end
        o_pending <= stats_due.size();
    end

endmodule

// ----- test/laplacian_variance_blur_metric_test.sv -----
`timescale 1ns / 1ps
// Testbench top: drives frames of luma beats and geometry writes, then gives the verdict.
module laplacian_variance_blur_metric_test;
    import lvbm_pkg::*;

    // This pause gives the back end time to finish a frame, with margin, before any
    // geometry write and before the verdict.
    localparam int DRAIN_CYCLES    = 200;
    // Long enough for several small frames to pile up behind a blocked result port.
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int PIXEL_TARGET    = 1550;
    localparam int FRAME_TARGET    = 40;
    localparam longint LIMIT_NS    = 50_000_000;

    typedef enum {TEX_NOISE, TEX_EXTREME, TEX_RAMP, TEX_CHECKER, TEX_FLAT} t_texture;
    typedef enum {HOLD_IDLE, HOLD_ASKED, HOLD_ON, HOLD_DONE} t_hold_state;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    t_cfg_index               i_cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0]         i_cfg_data  = '0;
    logic                     i_valid     = 1'b0;
    logic [LUMA_W-1:0]        i_luma      = '0;
    logic                     i_stall     = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic [VAR_W-1:0]         o_blur_variance_q8;
    logic signed [MEAN_W-1:0] o_laplacian_mean_q8;

    int          fail_count;
    int          frames_pending;
    t_hold_state hold_state = HOLD_IDLE;
    int          pixels_sent = 0;
    int          frames_sent = 0;
    int unsigned cur_w;
    int unsigned cur_h;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    laplacian_variance_blur_metric uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_luma              (i_luma),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_blur_variance_q8  (o_blur_variance_q8),
        .o_laplacian_mean_q8 (o_laplacian_mean_q8)
    );

    laplacian_variance_blur_metric_checker u_focus_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_luma              (i_luma),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_blur_variance_q8  (o_blur_variance_q8),
        .o_laplacian_mean_q8 (o_laplacian_mean_q8),
        .o_fail_count        (fail_count),
        .o_pending           (frames_pending)
    );

    // Mostly back-to-back beats, some short gaps and now and then a long one.
    function automatic int pixel_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Effective frame size as the block clamps it; used only to know how many beats to send.
    function automatic int unsigned clamped_dim(input logic [CFG_W-1:0] raw, input int hi);
        if (raw < MIN_DIM) return MIN_DIM;
        if (raw > hi) return hi;
        return raw;
    endfunction

    function automatic logic [LUMA_W-1:0] texel(input t_texture tex, input int x, input int y,
                                                 input logic [LUMA_W-1:0] base,
                                                 input int sx, input int sy);
        case (tex)
            TEX_NOISE:   return LUMA_W'($urandom_range(0, 255));
            TEX_EXTREME: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            TEX_RAMP:    return LUMA_W'(base + x * sx + y * sy + $urandom_range(0, 3));
            TEX_CHECKER: return ((x + y) % 2 != 0) ? 8'd0 : 8'd255;
            default:     return base;
        endcase
    endfunction

    // Offers one beat and returns at the edge that takes it. Valid is left high so the
    // next beat can follow without a bubble; only a gap lowers it.
    task automatic push_pixel(input logic [LUMA_W-1:0] value, input bit steady);
        int gap;
        gap = steady ? 0 : pixel_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_luma  <= value;
        do @(posedge i_clk); while (o_stall);
        pixels_sent++;
    endtask

    task automatic push_frame(input t_texture tex, input bit steady);
        logic [LUMA_W-1:0] base;
        int                sx;
        int                sy;
        base = LUMA_W'($urandom_range(0, 255));
        sx   = $urandom_range(0, 40);
        sy   = $urandom_range(0, 40);
        for (int y = 0; y < cur_h; y++) begin
            for (int x = 0; x < cur_w; x++) begin
                push_pixel(texel(tex, x, y, base, sx, sy), steady);
            end
        end
        frames_sent++;
    endtask

    // Waits until every frame result has come back, then lets the back end settle.
    // The pending count is registered, so the first look waits for a clock edge.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (frames_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Geometry changes only between frames, with the block idle.
    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= CFG_FRAME_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_w = clamped_dim(w, MAX_WIDTH_DEF);
        cur_h = clamped_dim(h, MAX_HEIGHT_DEF);
    endtask

    // Result side: random stalls with quiet stretches, plus one long hold-off on request.
    initial begin
        int pick;
        int stall_len;
        int run_len;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_state == HOLD_ASKED) begin
                i_stall    <= 1'b1;
                hold_state = HOLD_ON;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_state = HOLD_DONE;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                stall_len = 0;
                run_len   = $urandom_range(30, 200);
            end else if (pick < 88) begin
                stall_len = $urandom_range(0, 3);
                run_len   = $urandom_range(1, 8);
            end else begin
                stall_len = $urandom_range(10, 80);
                run_len   = $urandom_range(1, 8);
            end
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat (run_len) @(posedge i_clk);
        end
    end

    initial begin
        int phase;
        int pick;
        phase = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Both sizes below range clamp to 3x3: a single interior pixel, so the variance
        // is zero. A dark centre in a white frame gives the largest positive mean.
        set_geometry(CFG_W'(0), CFG_W'(1));
        for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 3; x++) begin
                push_pixel((x == 1 && y == 1) ? 8'd0 : 8'd255, 1'b0);
            end
        end
        frames_sent++;

        // A 4x3 checkerboard gives two interior values of opposite extreme sign: the mean
        // is zero and the variance saturates the field.
        set_geometry(CFG_W'(4), CFG_W'(3));
        push_frame(TEX_CHECKER, 1'b0);

        while (pixels_sent < PIXEL_TARGET || frames_sent < FRAME_TARGET) begin
            if (phase == 2) begin
                // A wide row on the shortest frame, the height written from below range.
                set_geometry(CFG_W'(64), CFG_W'(0));
                push_frame(TEX_NOISE, 1'b0);
            end else if (phase == 4) begin
                // Result port held off while small frames keep coming, so the result
                // queue fills and the pixel input must stall.
                set_geometry(CFG_W'($urandom_range(3, 5)), CFG_W'(3));
                hold_state = HOLD_ASKED;
                wait (hold_state == HOLD_ON);
                repeat (8) push_frame(TEX_NOISE, 1'b1);
            end else if (phase == 5) begin
                // A tall frame on the narrowest row, the width written from below range.
                set_geometry(CFG_W'(2), CFG_W'(64));
                push_frame(TEX_RAMP, 1'b0);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    set_geometry(CFG_W'($urandom_range(3, 10)), CFG_W'($urandom_range(3, 8)));
                end else if (pick < 92) begin
                    set_geometry(CFG_W'($urandom_range(11, 40)), CFG_W'($urandom_range(3, 12)));
                end else begin
                    set_geometry(CFG_W'($urandom_range(0, 2)), CFG_W'($urandom_range(0, 2)));
                end
                repeat ($urandom_range(1, 3)) begin
                    push_frame(t_texture'($urandom_range(0, 4)), $urandom_range(0, 3) == 0);
                end
            end
            phase++;
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Far beyond the slowest legal run, so only a hung block gets here.
    initial begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
